### hdl/bprb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bprb_pkg
// Shared types, constants and helpers for the packed raw binning unit.
// ----------------------------------------------------------------------------
package bprb_pkg;

  // sizes of the raw word and its channels
  localparam int RAW_W  = 60;
  localparam int CH_W   = 10;
  localparam int PIX_W  = 8;
  localparam int WPL_W  = 9;
  localparam int PPL_W  = 10;
  localparam int CFG_W  = 10;

  // default line store depth in words
  localparam int MAX_WORDS_DEF = 256;

  // register reset values
  localparam logic [WPL_W-1:0] WPL_RESET = 9'd214;
  localparam logic [PPL_W-1:0] PPL_RESET = 10'd640;

  // register indexes
  typedef enum logic {
    CFG_WORDS_PER_LINE  = 1'b0,
    CFG_PIXELS_PER_LINE = 1'b1
  } cfg_idx_t;

  // queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int QAW     = 2;
  localparam int QCW     = 3;
  localparam logic [QCW-1:0] Q_FULL = 3'd4;

  // pixel position inside a word
  localparam logic [1:0] LAST_PIX = 2'd2;

  // one odd-row word paired with its even-row word
  typedef struct packed {
    logic [RAW_W-1:0] top;
    logic [RAW_W-1:0] bot;
    logic [PPL_W-1:0] base;
    logic             row_end;
  } q_entry_t;

  // queue status seen by front and back
  typedef struct packed {
    logic           empty;
    logic [QCW-1:0] count;
  } q_stat_t;

  // pick channel idx (0..5) out of a raw word
  function automatic logic [CH_W-1:0] chan(input logic [RAW_W-1:0] w,
                                           input logic [2:0] idx);
    logic [CH_W-1:0] r;
    case (idx)
      3'd0:    r = w[9:0];
      3'd1:    r = w[19:10];
      3'd2:    r = w[29:20];
      3'd3:    r = w[39:30];
      3'd4:    r = w[49:40];
      3'd5:    r = w[59:50];
      default: r = '0;
    endcase
    return r;
  endfunction

  // saturate a channel to eight bits
  function automatic logic [PIX_W-1:0] clamp8(input logic [CH_W-1:0] v);
    return (v > CH_W'(255)) ? PIX_W'(255) : v[PIX_W-1:0];
  endfunction

endpackage

### hdl/bprb_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bprb_front
// Accepts raw words, tracks row and column, keeps the even row in a line
// store and queues each kept odd-row word with its stored partner.
// ----------------------------------------------------------------------------
module bprb_front #(
  parameter int MAX_WORDS = bprb_pkg::MAX_WORDS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [bprb_pkg::RAW_W-1:0]  in_raw_word,
  input  logic                        in_frame_start,
  input  logic [bprb_pkg::WPL_W-1:0]  words_per_line,
  input  logic [bprb_pkg::PPL_W-1:0]  pixels_per_line,
  input  bprb_pkg::q_stat_t           q_stat,
  output logic                        push,
  output bprb_pkg::q_entry_t          push_data
);
  import bprb_pkg::*;

  localparam int CW     = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int CMP_W  = (CW + 1 > WPL_W) ? CW + 1 : WPL_W;
  localparam int BW     = (CW + 2 > PPL_W) ? CW + 2 : PPL_W;
  localparam logic [CW-1:0] COL_LAST = CW'(MAX_WORDS - 1);

  logic [CW-1:0]     col_r, col_nxt, col_cur;
  logic              odd_r, odd_nxt, odd_cur;
  logic              acc, row_end, keep;
  logic [CMP_W-1:0]  col_p1;
  logic [BW-1:0]     base;

  logic              s1_push_r;
  logic [RAW_W-1:0]  s1_word_r;
  logic [PPL_W-1:0]  s1_base_r;
  logic              s1_row_end_r;
  logic [RAW_W-1:0]  rdata_r;

  logic [RAW_W-1:0]  store [MAX_WORDS];

  // hold input while a queued word could find the queue full
  assign in_stall = (q_stat.count + QCW'(s1_push_r)) >= Q_FULL;
  assign acc      = in_valid && !in_stall;

  // position of this word
  always_comb begin
    col_cur = in_frame_start ? '0 : col_r;
    odd_cur = in_frame_start ? 1'b0 : odd_r;
    col_p1  = CMP_W'(col_cur) + CMP_W'(1);
    row_end = (col_p1 >= CMP_W'(words_per_line)) || (col_cur == COL_LAST);
    base    = BW'(col_cur) + (BW'(col_cur) << 1);
    keep    = base < BW'(pixels_per_line);
    if (row_end) begin
      col_nxt = '0;
      odd_nxt = !odd_cur;
    end else begin
      col_nxt = col_p1[CW-1:0];
      odd_nxt = odd_cur;
    end
  end

  // row and column counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      odd_r     <= 1'b0;
      s1_push_r <= 1'b0;
    end else begin
      if (acc) begin
        col_r <= col_nxt;
        odd_r <= odd_nxt;
      end
      s1_push_r <= acc && odd_cur && keep;
    end
  end

  // word held for the store read
  always_ff @(posedge clk) begin
    if (acc) begin
      s1_word_r    <= in_raw_word;
      s1_base_r    <= base[PPL_W-1:0];
      s1_row_end_r <= row_end;
    end
  end

  // even-row line store
  always_ff @(posedge clk) begin
    if (acc && !odd_cur) begin
      store[col_cur] <= in_raw_word;
    end
    if (acc) begin
      rdata_r <= store[col_cur];
    end
  end

  // queue write
  assign push              = s1_push_r;
  assign push_data.top     = rdata_r;
  assign push_data.bot     = s1_word_r;
  assign push_data.base    = s1_base_r;
  assign push_data.row_end = s1_row_end_r;

  // column never runs past the store
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= COL_LAST)
    else $error("column counter past line store");

endmodule

### hdl/bprb_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bprb_fifo
// Short queue of paired words between the front and the pixel back end.
// ----------------------------------------------------------------------------
module bprb_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  bprb_pkg::q_entry_t   push_data,
  input  logic                 pop,
  output bprb_pkg::q_entry_t   head,
  output bprb_pkg::q_stat_t    q_stat
);
  import bprb_pkg::*;

  q_entry_t        entry_r [Q_DEPTH];
  logic [QAW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QCW-1:0]  count_r, count_nxt;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + QCW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCW'(1);
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QAW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QAW'(1);
      end
      count_r <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  assign head         = entry_r[rd_ptr_r];
  assign q_stat.count = count_r;
  assign q_stat.empty = (count_r == '0);

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (count_r != Q_FULL))
    else $error("word queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (count_r != '0))
    else $error("word queue underflow");

endmodule

### hdl/bprb_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bprb_back
// Turns each queued word pair into up to three RGB pixels, one per cycle
// while the output is not stalled, into an output register.
// ----------------------------------------------------------------------------
module bprb_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [bprb_pkg::PPL_W-1:0]  pixels_per_line,
  input  bprb_pkg::q_stat_t           q_stat,
  input  bprb_pkg::q_entry_t          head,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [bprb_pkg::PIX_W-1:0]  out_red,
  output logic [bprb_pkg::PIX_W-1:0]  out_green,
  output logic [bprb_pkg::PIX_W-1:0]  out_blue,
  output logic                        out_line_end,
  output logic                        out_last
);
  import bprb_pkg::*;

  logic [1:0]        k_r;
  logic              out_vld_r;
  logic [PIX_W-1:0]  red_r, green_r, blue_r;
  logic              line_end_r, last_r;

  logic              load, is_last, line_end;
  logic [PPL_W:0]    pix1;
  logic [2:0]        idx_even, idx_odd;
  logic [CH_W:0]     g_sum;
  logic [CH_W-1:0]   g_mean;

  // pixel k of the head entry
  always_comb begin
    load     = !q_stat.empty && (!out_vld_r || !out_stall);
    idx_even = {k_r, 1'b0};
    idx_odd  = {k_r, 1'b1};
    pix1     = (PPL_W+1)'(head.base) + (PPL_W+1)'(k_r) + (PPL_W+1)'(1);
    is_last  = (k_r == LAST_PIX) || (pix1 >= (PPL_W+1)'(pixels_per_line));
    line_end = (pix1 == (PPL_W+1)'(pixels_per_line)) ||
               (head.row_end && (k_r == LAST_PIX));
    g_sum    = (CH_W+1)'(chan(head.top, idx_odd)) + (CH_W+1)'(chan(head.bot, idx_even));
    g_mean   = g_sum[CH_W:1];
  end

  assign pop = load && is_last;

  // pixel counter and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r       <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (load) begin
        k_r       <= is_last ? 2'd0 : k_r + 2'd1;
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (load) begin
      red_r      <= clamp8(chan(head.top, idx_even));
      green_r    <= clamp8(g_mean);
      blue_r     <= clamp8(chan(head.bot, idx_odd));
      line_end_r <= line_end;
      last_r     <= is_last;
    end
  end

  assign out_valid    = out_vld_r;
  assign out_red      = red_r;
  assign out_green    = green_r;
  assign out_blue     = blue_r;
  assign out_line_end = line_end_r;
  assign out_last     = last_r;

  // a word in progress stays at the queue head
  a_head_held: assert property (@(posedge clk) disable iff (!rst_n)
    (k_r != 2'd0) |-> !q_stat.empty)
    else $error("pixel counter mid-word with empty queue");

endmodule

### hdl/bayer_packed_raw_bin_to_rgb_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bayer_packed_raw_bin_to_rgb_unit
// 2x2 Bayer binning of packed 10-bit raw words into RGB888 pixels.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  in_      sink       in_valid / in_stall  in_raw_word, in_frame_start
//  out_     source     out_valid/out_stall  out_red/green/blue, line_end, last
//  cfg_     sink       cfg_wr_en            cfg_index, cfg_wdata
//
// An even-row word gives no pixel. An odd-row word gives up to three
// pixels, one per cycle from the back end while out_stall is low; the
// back end's single pixel path limits the rate of an odd row.
// A word is pushed to the queue in the cycle after it is taken (line store
// read); its first pixel then goes through the queue to the output register.
// Reset is synchronous; the line store needs no clearing pass.
// in_stall rises when the four-entry queue may fill; out_stall holds the
// output register and, through the queue, the input.
// ----------------------------------------------------------------------------
module bayer_packed_raw_bin_to_rgb_unit #(
  parameter int MAX_WORDS = bprb_pkg::MAX_WORDS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [bprb_pkg::RAW_W-1:0]  in_raw_word,
  input  logic                        in_frame_start,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [bprb_pkg::PIX_W-1:0]  out_red,
  output logic [bprb_pkg::PIX_W-1:0]  out_green,
  output logic [bprb_pkg::PIX_W-1:0]  out_blue,
  output logic                        out_line_end,
  output logic                        out_last,
  input  logic                        cfg_wr_en,
  input  bprb_pkg::cfg_idx_t          cfg_index,
  input  logic [bprb_pkg::CFG_W-1:0]  cfg_wdata
);
  import bprb_pkg::*;

  logic [WPL_W-1:0] wpl_r;
  logic [PPL_W-1:0] ppl_r;
  logic             push, pop;
  q_entry_t         push_data, head;
  q_stat_t          q_stat;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wpl_r <= WPL_RESET;
      ppl_r <= PPL_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_WORDS_PER_LINE:  wpl_r <= cfg_wdata[WPL_W-1:0];
        CFG_PIXELS_PER_LINE: ppl_r <= cfg_wdata[PPL_W-1:0];
        default:             ;
      endcase
    end
  end

  bprb_front #(
    .MAX_WORDS (MAX_WORDS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_raw_word     (in_raw_word),
    .in_frame_start  (in_frame_start),
    .words_per_line  (wpl_r),
    .pixels_per_line (ppl_r),
    .q_stat          (q_stat),
    .push            (push),
    .push_data       (push_data)
  );

  bprb_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  bprb_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .pixels_per_line (ppl_r),
    .q_stat          (q_stat),
    .head            (head),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_red         (out_red),
    .out_green       (out_green),
    .out_blue        (out_blue),
    .out_line_end    (out_line_end),
    .out_last        (out_last)
  );

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the packed raw 2x2 binning unit.
// Drives raw sensor words through a table of directed rows and then random
// frames under several line geometries and pacing modes. Every accepted
// word goes through a bench-side binning predictor, and every pixel taken
// from the block is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import bprb_pkg::*;

  localparam int LINE_WORDS   = MAX_WORDS_DEF;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_SLACK  = 8;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int SMALL_WORDS  = 20;

  // uniform channel patterns for the directed rows
  localparam logic [RAW_W-1:0] W_ZERO = '0;
  localparam logic [RAW_W-1:0] W_ONES = '1;
  localparam logic [RAW_W-1:0] W_C255 = {6{10'd255}};
  localparam logic [RAW_W-1:0] W_C256 = {6{10'd256}};
  localparam logic [RAW_W-1:0] W_C510 = {6{10'd510}};
  localparam logic [RAW_W-1:0] W_C200 = {6{10'd200}};
  localparam logic [RAW_W-1:0] W_C100 = {6{10'd100}};

  typedef enum logic [1:0] {
    PACE_FULL,
    PACE_SEND_IDLE,
    PACE_RECV_STALL,
    PACE_BOTH
  } pace_t;

  typedef enum logic {
    ROW_GEOMETRY,
    ROW_WORD
  } row_kind_t;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic             line_end;
    logic             last;
  } rgb_pixel_t;

  typedef struct packed {
    row_kind_t        kind;
    logic             fs;
    logic [RAW_W-1:0] word;
    logic             random_word;
    logic             typed;
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic [WPL_W-1:0] wpl;
    logic [PPL_W-1:0] ppl;
  } dir_row_t;

  // directed rows: geometry writes, clamp extremes, dropped and short rows
  localparam int DIR_ROWS = 29;
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    '{ROW_GEOMETRY, 1'b0, W_ZERO, 1'b0, 1'b0, 8'd0,   8'd0,   8'd0,   9'd1, 10'd1023},
    '{ROW_WORD,     1'b1, W_ONES, 1'b0, 1'b0, 8'd0,   8'd0,   8'd0,   9'd0, 10'd0},
    '{ROW_WORD,     1'b0, W_ONES, 1'b0, 1'b1, 8'd255, 8'd255, 8'd255, 9'd0, 10'd0},
    '{ROW_WORD,     1'b0, W_ZERO, 1'b0, 1'b0, 8'd0,   8'd0,   8'd0,   9'd0, 10'd0},
    '{ROW_WORD,     1'b0, W_ZERO, 1'b0, 1'b1, 8'd0,   8'd0,   8'd0,   9'd0, 10'd0},
    '{ROW_WORD,     1'b0, W_C255, 1'b0, 1'b0, 8'd0,   8'd0,   8'd0,   9'd0, 10'd0},
    '{ROW_WORD,     1'b0, W_C256, 1'b0, 1'b1, 8'd255, 8'd255, 8'd255, 9'd0, 10'd0},
    '{ROW_WORD,     1'b0, W_ONES, 1'b0, 1'b0, 8'd0,   8'd0,   8'd0,   9'd0, 10'd0},
    '{ROW_WORD,     1'b0, W_ZERO, 1'b0, 1'b1, 8'd255, 8'd255, 8'd0,   9'd0, 10'd0},
    '{ROW_WORD,     1'b0, W_ZERO, 1'b0, 1'b0, 8'd0,   8'd0,   8'd0,   9'd0, 10'd0},
    '{ROW_WORD,     1'b0, W_C510, 1'b0, 1'b1, 8'd0,   8'd255, 8'd255, 9'd0, 10'd0},
    '{ROW_WORD,     1'b0, W_C200, 1'b0, 1'b0, 8'd0,   8'd0,   8'd0,   9'd0, 10'd0},
    '{ROW_WORD,     1'b0, W_C100, 1'b0, 1'b1, 8'd200, 8'd150, 8'd100, 9'd0, 10'd0},
    // zero row length acts as one word, third pixel dropped
    '{ROW_GEOMETRY, 1'b0, W_ZERO, 1'b0, 1'b0, 8'd0,   8'd0,   8'd0,   9'd0, 10'd2},
    '{ROW_WORD,     1'b1, W_ZERO, 1'b1, 1'b0, 8'd0,   8'd0,   8'd0,   9'd0, 10'd0},
    '{ROW_WORD,     1'b0, W_ZERO, 1'b1, 1'b0, 8'd0,   8'd0,   8'd0,   9'd0, 10'd0},
    // no pixels kept at all
    '{ROW_GEOMETRY, 1'b0, W_ZERO, 1'b0, 1'b0, 8'd0,   8'd0,   8'd0,   9'd1, 10'd0},
    '{ROW_WORD,     1'b1, W_ZERO, 1'b1, 1'b0, 8'd0,   8'd0,   8'd0,   9'd0, 10'd0},
    '{ROW_WORD,     1'b0, W_ZERO, 1'b1, 1'b0, 8'd0,   8'd0,   8'd0,   9'd0, 10'd0},
    // pixel row cut inside the second word
    '{ROW_GEOMETRY, 1'b0, W_ZERO, 1'b0, 1'b0, 8'd0,   8'd0,   8'd0,   9'd2, 10'd4},
    '{ROW_WORD,     1'b1, W_ZERO, 1'b1, 1'b0, 8'd0,   8'd0,   8'd0,   9'd0, 10'd0},
    '{ROW_WORD,     1'b0, W_ZERO, 1'b1, 1'b0, 8'd0,   8'd0,   8'd0,   9'd0, 10'd0},
    '{ROW_WORD,     1'b0, W_ZERO, 1'b1, 1'b0, 8'd0,   8'd0,   8'd0,   9'd0, 10'd0},
    '{ROW_WORD,     1'b0, W_ZERO, 1'b1, 1'b0, 8'd0,   8'd0,   8'd0,   9'd0, 10'd0},
    // pixel row longer than the sensor row
    '{ROW_GEOMETRY, 1'b0, W_ZERO, 1'b0, 1'b0, 8'd0,   8'd0,   8'd0,   9'd2, 10'd9},
    '{ROW_WORD,     1'b1, W_ZERO, 1'b1, 1'b0, 8'd0,   8'd0,   8'd0,   9'd0, 10'd0},
    '{ROW_WORD,     1'b0, W_ZERO, 1'b1, 1'b0, 8'd0,   8'd0,   8'd0,   9'd0, 10'd0},
    '{ROW_WORD,     1'b0, W_ZERO, 1'b1, 1'b0, 8'd0,   8'd0,   8'd0,   9'd0, 10'd0},
    '{ROW_WORD,     1'b0, W_ZERO, 1'b1, 1'b0, 8'd0,   8'd0,   8'd0,   9'd0, 10'd0}
  };

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic [RAW_W-1:0] in_raw_word;
  logic             in_frame_start;
  logic             out_valid;
  logic             out_stall;
  logic [PIX_W-1:0] out_red;
  logic [PIX_W-1:0] out_green;
  logic [PIX_W-1:0] out_blue;
  logic             out_line_end;
  logic             out_last;
  logic             cfg_wr_en;
  cfg_idx_t         cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  // bench copy of the block state
  logic [RAW_W-1:0] even_row_words [LINE_WORDS];
  logic [7:0]       word_col;
  logic             on_odd_row;
  logic [WPL_W-1:0] words_per_line_cfg;
  logic [PPL_W-1:0] pixels_per_line_cfg;

  rgb_pixel_t expected_pixels [$];
  int         mismatches = 0;
  int         cycle_count;
  pace_t      pace;
  logic       hold_request;

  bayer_packed_raw_bin_to_rgb_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_raw_word    (in_raw_word),
    .in_frame_start (in_frame_start),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .out_line_end   (out_line_end),
    .out_last       (out_last),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  // 100 MHz clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // saturate an 11-bit channel sum to eight bits
  function automatic logic [PIX_W-1:0] sat8(input logic [10:0] v);
    return (v > 11'd255) ? 8'd255 : v[PIX_W-1:0];
  endfunction

  // random raw word, channels often near the clamp point
  function automatic logic [RAW_W-1:0] raw_sample();
    logic [RAW_W-1:0] w;
    int ch;
    w = '0;
    for (ch = 0; ch < 6; ch++) begin
      if ($urandom_range(3) == 0) begin
        w[CH_W*ch +: CH_W] = CH_W'($urandom_range(260, 250));
      end else begin
        w[CH_W*ch +: CH_W] = CH_W'($urandom_range(1023));
      end
    end
    return w;
  endfunction

  // store an even-row word or bin an odd-row word into expected pixels
  task automatic bin_word(input logic [RAW_W-1:0] w, input logic fs, input logic typed,
                          input logic [PIX_W-1:0] tr, input logic [PIX_W-1:0] tg,
                          input logic [PIX_W-1:0] tb);
    int unsigned c;
    int unsigned px;
    int unsigned kept;
    int k;
    logic row_done;
    logic [RAW_W-1:0] top;
    rgb_pixel_t p;
    if (fs) begin
      word_col = '0;
      on_odd_row = 1'b0;
    end
    c = word_col;
    row_done = (c + 1 >= words_per_line_cfg) || (c + 1 >= LINE_WORDS);
    if (!on_odd_row) begin
      even_row_words[c] = w;
    end else begin
      top = even_row_words[c];
      if (pixels_per_line_cfg <= c * 3) begin
        kept = 0;
      end else if (pixels_per_line_cfg - c * 3 >= 3) begin
        kept = 3;
      end else begin
        kept = pixels_per_line_cfg - c * 3;
      end
      for (k = 0; k < kept; k++) begin
        px = c * 3 + k;
        p.red   = sat8(11'(top[20*k +: CH_W]));
        p.green = sat8((11'(top[20*k+10 +: CH_W]) + 11'(w[20*k +: CH_W])) >> 1);
        p.blue  = sat8(11'(w[20*k+10 +: CH_W]));
        p.line_end = (px + 1 == pixels_per_line_cfg) || (row_done && k == 2);
        p.last = (k == kept - 1);
        if (typed) begin
          p.red = tr;
          p.green = tg;
          p.blue = tb;
        end
        expected_pixels.push_back(p);
      end
    end
    if (row_done) begin
      word_col = '0;
      on_odd_row = ~on_odd_row;
    end else begin
      word_col = 8'(c + 1);
    end
  endtask

  // offer one word, with optional idle cycles first, and predict on accept
  task automatic offer_word(input logic [RAW_W-1:0] w, input logic fs, input logic typed,
                            input logic [PIX_W-1:0] tr, input logic [PIX_W-1:0] tg,
                            input logic [PIX_W-1:0] tb);
    int pct;
    pct = (pace == PACE_SEND_IDLE) ? 60 : (pace == PACE_BOTH) ? 21 : 0;
    if (pct > 0 && $urandom_range(99) < pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < pct);
    end
    in_valid <= 1'b1;
    in_raw_word <= w;
    in_frame_start <= fs;
    do @(posedge clk); while (in_stall);
    bin_word(w, fs, typed, tr, tg, tb);
  endtask

  // stop offering and wait until every predicted pixel is out
  task automatic drain_block();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  // write both line geometry registers, block idle
  task automatic write_geometry(input logic [WPL_W-1:0] wpl, input logic [PPL_W-1:0] ppl);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_WORDS_PER_LINE;
    cfg_wdata <= CFG_W'(wpl);
    @(posedge clk);
    cfg_index <= CFG_PIXELS_PER_LINE;
    cfg_wdata <= CFG_W'(ppl);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    words_per_line_cfg = wpl;
    pixels_per_line_cfg = ppl;
    @(posedge clk);
  endtask

  task automatic check_field(input string what, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      mismatches++;
    end
  endtask

  // compare each pixel taken from the block with the oldest prediction
  always @(posedge clk) begin : pixel_monitor
    rgb_pixel_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected pixel, expected none, actual r=%0d g=%0d b=%0d le=%0b l=%0b",
                 $time, out_red, out_green, out_blue, out_line_end, out_last);
        mismatches++;
      end else begin
        want = expected_pixels.pop_front();
        check_field("red", want.red, out_red);
        check_field("green", want.green, out_green);
        check_field("blue", want.blue, out_blue);
        check_field("line_end", want.line_end, out_line_end);
        check_field("last", want.last, out_last);
      end
    end
  end

  // receiver: random stalls, or one long hold-off on request
  initial begin : receiver
    int held;
    int pct;
    logic hold_done;
    hold_done = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      pct = (pace == PACE_RECV_STALL) ? 60 : (pace == PACE_BOTH) ? 21 : 0;
      if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < pct);
      end
    end
  end

  // run limit
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("bayer_packed_raw_bin_to_rgb_unit verification failed");
    $finish;
  end

  initial begin : stimulus
    dir_row_t row;
    logic [WPL_W-1:0] wpl;
    logic [PPL_W-1:0] ppl;
    int eff;
    int i;
    int ph;
    int n_words;

    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_raw_word <= '0;
    in_frame_start <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_index <= CFG_WORDS_PER_LINE;
    cfg_wdata <= '0;
    hold_request = 1'b0;
    pace = PACE_BOTH;
    word_col = '0;
    on_odd_row = 1'b0;
    words_per_line_cfg = WPL_RESET;
    pixels_per_line_cfg = PPL_RESET;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    for (i = 0; i < DIR_ROWS; i++) begin
      row = DIRECTED[i];
      if (row.kind == ROW_GEOMETRY) begin
        drain_block();
        write_geometry(row.wpl, row.ppl);
      end else begin
        offer_word(row.random_word ? raw_sample() : row.word, row.fs, row.typed,
                   row.red, row.green, row.blue);
      end
    end

    // random frames; phase 3 runs a pixel row longer than the sensor row
    for (ph = 0; ph < 7; ph++) begin
      drain_block();
      pace = pace_t'(ph % 4);
      if (ph == 0) begin
        wpl = 9'd2;
        ppl = 10'd6;
        n_words = SMALL_WORDS;
      end else if (ph == 3) begin
        wpl = 9'd7;
        ppl = 10'd768;
        n_words = SMALL_WORDS;
      end else begin
        wpl = WPL_W'($urandom_range(6));
        eff = (wpl == 0) ? 1 : wpl;
        case ($urandom_range(9))
          0:       ppl = '0;
          1:       ppl = '1;
          default: ppl = PPL_W'($urandom_range(3 * eff + 2, 1));
        endcase
        n_words = SMALL_WORDS;
      end
      write_geometry(wpl, ppl);
      // long receiver hold-off while words keep coming
      if (ph == 0) hold_request = 1'b1;
      for (i = 0; i < n_words; i++) begin
        offer_word(raw_sample(), (i == 0) || ($urandom_range(24) == 0), 1'b0,
                   8'd0, 8'd0, 8'd0);
      end
    end

    drain_block();
    if (mismatches == 0) begin
      $display("bayer_packed_raw_bin_to_rgb_unit verification clean");
    end else begin
      $display("bayer_packed_raw_bin_to_rgb_unit verification failed");
    end
    $finish;
  end

endmodule
